// File: rtl/ckt_pkg.sv
// Shared types and constants of the capped keyed entry table.
`default_nettype none

package ckt_pkg;

   // Field widths fixed by the transaction format
   localparam int IDX_W   = 6;
   localparam int LIMIT_W = 7;
   localparam int KIND_W  = 3;
   localparam int SITE_W  = 64;
   localparam int CWID_W  = 4;
   localparam int DATA_W  = 64;
   localparam int TAGS_W  = 5;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   // Register indexes on the configuration port (paddr[3:2])
   localparam logic [1:0] REG_PER_KIND_LIMIT = 2'd0;
   localparam logic [1:0] REG_EXACT_KIND     = 2'd1;
   localparam logic [1:0] REG_RANGE_KIND     = 2'd2;

   typedef enum logic [1:0] {
      OP_FIND_SITE  = 2'd0,
      OP_FIND_EXACT = 2'd1,
      OP_FIND_RANGE = 2'd2,
      OP_ALLOC      = 2'd3
   } ckt_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_QUOTA = 2'd3
   } ckt_status_type;

   typedef enum logic [1:0] {
      IDX_ZERO  = 2'd0,
      IDX_ALLOC = 2'd1,
      IDX_CMP   = 2'd2
   } ckt_idx_sel_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_DECIDE = 2'd1,
      S_SCAN   = 2'd2,
      S_RESP   = 2'd3
   } ckt_state_type;

   typedef struct packed {
      ckt_op_type          op;
      logic [KIND_W-1:0]   kind;
      logic [SITE_W-1:0]   site;
      logic [CWID_W-1:0]   cwidth;
      logic [DATA_W-1:0]   value;
      logic [DATA_W-1:0]   low;
      logic [DATA_W-1:0]   high;
      logic [TAGS_W-1:0]   tags;
   } ckt_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SITE_W-1:0]   site;
      logic [CWID_W-1:0]   cwidth;
      logic [DATA_W-1:0]   exemplar;
      logic [DATA_W-1:0]   low;
      logic [DATA_W-1:0]   high;
      logic [TAGS_W-1:0]   tags;
   } ckt_slot_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  per_kind_limit;
      logic [KIND_W-1:0]   exact_kind;
      logic [KIND_W-1:0]   range_kind;
   } ckt_cfg_type;

   typedef struct packed {
      logic            load;
      logic            alloc_wr;
      logic            scan_clr;
      logic            issue;
      logic            res_load;
      ckt_status_type  res_status;
      ckt_idx_sel_type res_idx_sel;
   } ckt_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic full;
      logic quota;
      logic empty;
      logic cmp_valid;
      logic hit;
      logic last;
   } ckt_stat_type;

endpackage

`default_nettype wire

// File: rtl/ckt_req_if.sv
// Request channel interface of the capped keyed entry table.
`default_nettype none

interface ckt_req_if;
   import ckt_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [KIND_W-1:0]   kind;
   logic [SITE_W-1:0]   site_address;
   logic [CWID_W-1:0]   compare_width;
   logic [DATA_W-1:0]   value;
   logic [DATA_W-1:0]   low_bound;
   logic [DATA_W-1:0]   high_bound;
   logic [1:0]          direction;
   logic                signedness;
   logic [1:0]          relation;

   modport source (
      output valid, operation, kind, site_address, compare_width, value,
             low_bound, high_bound, direction, signedness, relation,
      input  ready
   );

   modport sink (
      input  valid, operation, kind, site_address, compare_width, value,
             low_bound, high_bound, direction, signedness, relation,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/ckt_rsp_if.sv
// Response channel interface of the capped keyed entry table.
`default_nettype none

interface ckt_rsp_if;
   import ckt_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [IDX_W-1:0]  entry_index;

   modport source (
      output valid, status, entry_index,
      input  ready
   );

   modport sink (
      input  valid, status, entry_index,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/ckt_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module ckt_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [ckt_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [ckt_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic      [ckt_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output ckt_pkg::ckt_cfg_type              cfg
);
   import ckt_pkg::*;

   ckt_cfg_type cfg_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Update the addressed register on the access phase of a write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.per_kind_limit <= LIMIT_W'(16);
         cfg_ff.exact_kind     <= KIND_W'(0);
         cfg_ff.range_kind     <= KIND_W'(1);
      end else if (wr_en) begin
         case (reg_idx)
            REG_PER_KIND_LIMIT: cfg_ff.per_kind_limit <= csr_pwdata[LIMIT_W-1:0];
            REG_EXACT_KIND:     cfg_ff.exact_kind     <= csr_pwdata[KIND_W-1:0];
            REG_RANGE_KIND:     cfg_ff.range_kind     <= csr_pwdata[KIND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Return the addressed register, zero-extended
   always_comb begin
      case (reg_idx)
         REG_PER_KIND_LIMIT: csr_prdata = PDATA_W'(cfg_ff.per_kind_limit);
         REG_EXACT_KIND:     csr_prdata = PDATA_W'(cfg_ff.exact_kind);
         REG_RANGE_KIND:     csr_prdata = PDATA_W'(cfg_ff.range_kind);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ckt_ctrl.sv
// Sequencer that steers decode, allocation, slot scan and response.
`default_nettype none

module ckt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  ckt_pkg::ckt_stat_type      stat,
   output ckt_pkg::ckt_cmd_type       cmd
);
   import ckt_pkg::*;

   ckt_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      cmd             = '0;
      cmd.res_status  = ST_OK;
      cmd.res_idx_sel = IDX_ZERO;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_alloc) begin
               cmd.res_load = 1'b1;
               if (stat.full) begin
                  cmd.res_status = ST_FULL;
               end else if (stat.quota) begin
                  cmd.res_status = ST_QUOTA;
               end else begin
                  cmd.alloc_wr    = 1'b1;
                  cmd.res_idx_sel = IDX_ALLOC;
               end
               state_in = S_RESP;
            end else if (stat.empty) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_RESP;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // Advance one slot per cycle; stop at the first match
            cmd.issue = 1'b1;
            if (stat.cmp_valid && stat.hit) begin
               cmd.res_load    = 1'b1;
               cmd.res_idx_sel = IDX_CMP;
               state_in        = S_RESP;
            end else if (stat.cmp_valid && stat.last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ckt_dpath.sv
// Slot memory, occupancy counters, key compare and response registers.
`default_nettype none

module ckt_dpath #(
   parameter int ENTRIES = 64,
   parameter int KINDS   = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  ckt_pkg::ckt_req_type           req_in,
   input  ckt_pkg::ckt_cfg_type           cfg,
   input  ckt_pkg::ckt_cmd_type           cmd,
   output ckt_pkg::ckt_stat_type          stat,
   output logic [1:0]                     rsp_status,
   output logic [ckt_pkg::IDX_W-1:0]      rsp_entry_index
);
   import ckt_pkg::*;

   localparam int AW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int KW   = $clog2(KINDS);
   localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

   ckt_req_type     req_ff;
   logic [CW-1:0]   used_ff;
   logic [CW-1:0]   usage_ff [KINDS];
   ckt_slot_type    slot_mem [ENTRIES];
   ckt_slot_type    rd_ff;
   ckt_slot_type    slot_wdata;
   logic [CW-1:0]   iss_ff;
   logic [CW-1:0]   cmp_idx_ff;
   logic            cmp_valid_ff;
   ckt_status_type  res_status_ff;
   logic [IDX_W-1:0] res_idx_ff;

   logic            kind_ok;
   logic [KW-1:0]   kind_idx;
   logic [CW-1:0]   usage_sel;
   logic            more;
   logic            issue_en;
   logic            hit;

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
      end
   end

   assign kind_ok   = 32'(req_ff.kind) < KINDS;
   assign kind_idx  = KW'(req_ff.kind);
   assign usage_sel = usage_ff[kind_idx];
   assign more      = iss_ff < used_ff;
   assign issue_en  = cmd.issue && more;

   // Occupancy counters
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int k = 0; k < KINDS; k++) begin
            usage_ff[k] <= '0;
         end
      end else if (cmd.alloc_wr) begin
         used_ff            <= used_ff + CW'(1);
         usage_ff[kind_idx] <= usage_sel + CW'(1);
      end
   end

   assign slot_wdata = '{kind:     req_ff.kind,
                         site:     req_ff.site,
                         cwidth:   req_ff.cwidth,
                         exemplar: req_ff.value,
                         low:      req_ff.low,
                         high:     req_ff.high,
                         tags:     req_ff.tags};

   // Slot memory: append at the fill count, read one slot per cycle
   always_ff @(posedge clock) begin
      if (cmd.alloc_wr) begin
         slot_mem[used_ff[AW-1:0]] <= slot_wdata;
      end
      if (issue_en) begin
         rd_ff <= slot_mem[iss_ff[AW-1:0]];
      end
   end

   // Scan pointer and the slot under compare
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff       <= '0;
         cmp_idx_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         iss_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (cmd.issue) begin
         cmp_valid_ff <= more;
         if (more) begin
            iss_ff     <= iss_ff + CW'(1);
            cmp_idx_ff <= iss_ff;
         end
      end
   end

   // Key compare for the slot read last cycle
   always_comb begin
      case (req_ff.op)
         OP_FIND_SITE:  hit = (rd_ff.kind == req_ff.kind) && (rd_ff.site == req_ff.site) &&
                              (rd_ff.cwidth == req_ff.cwidth);
         OP_FIND_EXACT: hit = (rd_ff.kind == cfg.exact_kind) &&
                              (rd_ff.site == req_ff.site) &&
                              (rd_ff.cwidth == req_ff.cwidth) &&
                              (rd_ff.exemplar == req_ff.value);
         OP_FIND_RANGE: hit = (rd_ff.kind == cfg.range_kind) &&
                              (rd_ff.cwidth == req_ff.cwidth) &&
                              (rd_ff.low == req_ff.low) && (rd_ff.high == req_ff.high) &&
                              (rd_ff.tags == req_ff.tags);
         default:       hit = 1'b0;
      endcase
   end

   assign stat.is_alloc  = req_ff.op == OP_ALLOC;
   assign stat.full      = used_ff == CW'(ENTRIES);
   assign stat.quota     = !kind_ok ||
                           (CMPW'(usage_sel) >= CMPW'(cfg.per_kind_limit));
   assign stat.empty     = used_ff == '0;
   assign stat.cmp_valid = cmp_valid_ff;
   assign stat.hit       = hit;
   assign stat.last      = (cmp_idx_ff + CW'(1)) == used_ff;

   // Response registers
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         case (cmd.res_idx_sel)
            IDX_ALLOC: res_idx_ff <= IDX_W'(used_ff);
            IDX_CMP:   res_idx_ff <= IDX_W'(cmp_idx_ff);
            default:   res_idx_ff <= '0;
         endcase
      end
   end

   assign rsp_status      = res_status_ff;
   assign rsp_entry_index = res_idx_ff;

endmodule

`default_nettype wire

// File: rtl/capped_keyed_entry_table_top.sv
// Capped keyed entry table: an append-only table of keyed slots with a per-kind
// quota. One transaction is in flight at a time. An allocate is decided in the
// decide state after acceptance and its response is registered for the response state;
// a lookup reads the slot memory one slot per cycle from slot 0 upward and returns
// the first match, its scan bounded by the fill count and paced by the single read port of
// the slot memory. Slot contents are not cleared at reset; the fill count and
// the per-kind counters are, and lookups never read beyond the fill count.
`default_nettype none

module capped_keyed_entry_table_top #(
   parameter int ENTRIES = 64,
   parameter int KINDS   = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ckt_req_if.sink                           req_ch,
   ckt_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [ckt_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [ckt_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic      [ckt_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import ckt_pkg::*;

   ckt_cfg_type  cfg;
   ckt_cmd_type  cmd;
   ckt_stat_type stat;
   ckt_req_type  req_in;

   // Pack the request transaction
   assign req_in.op     = ckt_op_type'(req_ch.operation);
   assign req_in.kind   = req_ch.kind;
   assign req_in.site   = req_ch.site_address;
   assign req_in.cwidth = req_ch.compare_width;
   assign req_in.value  = req_ch.value;
   assign req_in.low    = req_ch.low_bound;
   assign req_in.high   = req_ch.high_bound;
   assign req_in.tags   = {req_ch.relation, req_ch.signedness, req_ch.direction};

   ckt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ckt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ckt_dpath #(
      .ENTRIES (ENTRIES),
      .KINDS   (KINDS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_in          (req_in),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_ch.status),
      .rsp_entry_index (rsp_ch.entry_index)
   );

endmodule

`default_nettype wire

// File: rtl/ckt_checker.sv
// Port-level checks of the capped keyed entry table, bound to the top level.
`default_nettype none

module ckt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [5:0]  rsp_entry_index
);
   import ckt_pkg::*;

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_entry_index))
      else $error("stalled response changed");

   // Drive a zero index on every refused or missed transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_entry_index == '0)
      else $error("non-zero index with failing status");

   // Drop ready once a transaction is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   // Never take a request while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // No response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind capped_keyed_entry_table_top ckt_checker u_ckt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_entry_index (rsp_ch.entry_index)
);

`default_nettype wire
